// ===== design/least_squares_line_fit_unit_assert.svh =====
// Assertion macros used by the line-fit port checker.
`ifndef LEAST_SQUARES_LINE_FIT_UNIT_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LSLF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LSLF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lslf_pkg.sv =====
// Package with the shared types and constants of the line-fit unit.
`timescale 1ns / 1ps

package lslf_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int COORD_W        = 16;
    localparam int RES_W          = 32;
    localparam int PTS_W          = 9;
    localparam int FRAC_SHIFT_M   = 16;
    localparam int FRAC_SHIFT_B   = 8;

    localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } lslf_in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] slope;
        logic signed [RES_W-1:0] intercept;
        logic                    singular;
        logic [PTS_W-1:0]        points_used;
    } lslf_out_t;

    // Operand pairs fed to the shared multiplier.
    typedef enum logic [2:0] {
        MP_N_SXX,
        MP_SX_SX,
        MP_N_SXY,
        MP_SX_SY,
        MP_SXX_SY,
        MP_SX_SXY
    } mul_pair_t;

    // Where a finished product goes.
    typedef enum logic [1:0] {
        PD_TMP,
        PD_DET,
        PD_NUM_M,
        PD_NUM_B
    } prod_dst_t;

    typedef struct packed {
        logic      mul_start;
        mul_pair_t mul_pair;
        prod_dst_t prod_dst;
        logic      div_start;
        logic      quot_to_slope;
        logic      out_load;
    } lslf_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic det_zero;
    } lslf_sts_t;

    localparam lslf_cmd_t CMD_IDLE = '{
        mul_start:     1'b0,
        mul_pair:      MP_N_SXX,
        prod_dst:      PD_TMP,
        div_start:     1'b0,
        quot_to_slope: 1'b0,
        out_load:      1'b0
    };

endpackage

// ===== design/lslf_mul.sv =====
// Shift-add signed multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module lslf_mul #(
    parameter int A_W = 40,
    parameter int B_W = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [A_W-1:0]     op_a,
    input  logic signed [B_W-1:0]     op_b,
    output logic                      done,
    output logic signed [A_W+B_W-1:0] product
);

    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(B_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [C_W-1:0]     cnt_reg;
    logic [P_W-1:0]     a_sh_reg;
    logic [B_W-1:0]     b_sh_reg;
    logic [P_W-1:0]     acc_reg;
    logic               neg_reg;
    logic signed [P_W-1:0] prod_reg;

    logic [A_W-1:0] a_mag;
    logic [B_W-1:0] b_mag;

    assign a_mag = op_a[A_W-1] ? (~unsigned'(op_a) + A_W'(1)) : unsigned'(op_a);
    assign b_mag = op_b[B_W-1] ? (~unsigned'(op_b) + B_W'(1)) : unsigned'(op_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= C_W'(B_W);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - C_W'(1);
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_sh_reg <= P_W'(a_mag);
            b_sh_reg <= b_mag;
            acc_reg  <= '0;
            neg_reg  <= op_a[A_W-1] ^ op_b[B_W-1];
        end else if (busy_reg && (cnt_reg != '0)) begin
            if (b_sh_reg[0]) begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end else if (busy_reg) begin
            // apply the sign once the magnitude is complete
            prod_reg <= neg_reg ? $signed(~acc_reg + P_W'(1)) : $signed(acc_reg);
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ===== design/lslf_div.sv =====
// Restoring divider, one quotient bit per cycle, saturated to the result width.
`timescale 1ns / 1ps

module lslf_div
    import lslf_pkg::*;
#(
    parameter int N_W = 81,
    parameter int D_W = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [N_W-1:0]  num,
    input  logic [D_W-1:0]         den,
    output logic                   done,
    output logic [RES_W-1:0]       quot
);

    localparam int C_W = $clog2(N_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [C_W-1:0]   cnt_reg;
    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic             neg_reg;
    logic [RES_W-1:0] quot_reg;

    logic [N_W-1:0]   num_mag;
    logic [D_W:0]     trial;
    logic [D_W:0]     trial_sub;
    logic             trial_ge;
    logic [D_W-1:0]   rem_next;
    logic [RES_W-1:0] q_low;
    logic             q_ovf;

    assign num_mag   = num[N_W-1] ? (~unsigned'(num) + N_W'(1)) : unsigned'(num);
    assign trial     = {rem_reg, q_reg[N_W-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign rem_next  = trial_ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
    assign q_low     = q_reg[RES_W-1:0];
    assign q_ovf     = |q_reg[N_W-1:RES_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= C_W'(N_W);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - C_W'(1);
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num_mag;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[N_W-1];
        end else if (busy_reg && (cnt_reg != '0)) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[N_W-2:0], trial_ge};
        end else if (busy_reg) begin
            if (neg_reg) begin
                quot_reg <= q_ovf ? SAT_NEG : (~q_low + RES_W'(1));
            end else begin
                quot_reg <= q_ovf ? SAT_POS : q_low;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/lslf_dp.sv =====
// Datapath: point sums, shared multiplier and divider, result register.
`timescale 1ns / 1ps

module lslf_dp
    import lslf_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_xfer,
    input  lslf_in_t  in_data,
    input  lslf_cmd_t cmd,
    output lslf_sts_t sts,
    output lslf_out_t out_data
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int LOG_M  = $clog2(MAX_POINTS);
    localparam int SUM_W  = COORD_W + LOG_M;
    localparam int SQ_W   = 2 * COORD_W + LOG_M;
    localparam int PROD_W = SQ_W + SUM_W;
    localparam int DIFF_W = PROD_W + 1;
    localparam int NUM_W  = DIFF_W + FRAC_SHIFT_M;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    // input product stage
    logic                        pend_reg;
    logic signed [COORD_W-1:0]   x_reg;
    logic signed [COORD_W-1:0]   y_reg;
    logic signed [2*COORD_W-1:0] xy_reg;
    logic signed [2*COORD_W-1:0] xx_reg;

    // running sums
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sx_reg;
    logic signed [SUM_W-1:0] sy_reg;
    logic signed [SQ_W-1:0]  sxy_reg;
    logic signed [SQ_W-1:0]  sxx_reg;

    // solve registers
    logic signed [PROD_W-1:0] tmp_reg;
    logic signed [DIFF_W-1:0] det_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [RES_W-1:0]         slope_reg;
    lslf_out_t                out_reg;

    logic signed [SQ_W-1:0]   mul_a;
    logic signed [SUM_W-1:0]  mul_b;
    logic signed [SUM_W-1:0]  n_op;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [DIFF_W-1:0] diff;
    logic                     div_done;
    logic [RES_W-1:0]         div_quot;
    logic                     det_zero;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            x_reg  <= in_data.point_x;
            y_reg  <= in_data.point_y;
            xy_reg <= in_data.point_x * in_data.point_y;
            xx_reg <= in_data.point_x * in_data.point_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxy_reg  <= '0;
            sxx_reg  <= '0;
        end else begin
            pend_reg <= in_xfer;
            if (cmd.out_load) begin
                cnt_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxy_reg <= '0;
                sxx_reg <= '0;
            end else if (pend_reg && (cnt_reg < CNT_MAX)) begin
                // drop points beyond the set limit
                cnt_reg <= cnt_reg + CNT_W'(1);
                sx_reg  <= sx_reg + SUM_W'(x_reg);
                sy_reg  <= sy_reg + SUM_W'(y_reg);
                sxy_reg <= sxy_reg + SQ_W'(xy_reg);
                sxx_reg <= sxx_reg + SQ_W'(xx_reg);
            end
        end
    end

    assign n_op = $signed(SUM_W'(cnt_reg));

    always_comb begin
        case (cmd.mul_pair)
            MP_N_SXX: begin
                mul_a = sxx_reg;
                mul_b = n_op;
            end
            MP_SX_SX: begin
                mul_a = SQ_W'(sx_reg);
                mul_b = sx_reg;
            end
            MP_N_SXY: begin
                mul_a = sxy_reg;
                mul_b = n_op;
            end
            MP_SX_SY: begin
                mul_a = SQ_W'(sy_reg);
                mul_b = sx_reg;
            end
            MP_SXX_SY: begin
                mul_a = sxx_reg;
                mul_b = sy_reg;
            end
            MP_SX_SXY: begin
                mul_a = sxy_reg;
                mul_b = sx_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lslf_mul #(
        .A_W (SQ_W),
        .B_W (SUM_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign diff = DIFF_W'(tmp_reg) - DIFF_W'(mul_prod);

    always_ff @(posedge aclk) begin
        if (mul_done) begin
            case (cmd.prod_dst)
                PD_TMP:   tmp_reg <= mul_prod;
                PD_DET:   det_reg <= diff;
                PD_NUM_M: num_reg <= NUM_W'(diff) <<< FRAC_SHIFT_M;
                PD_NUM_B: num_reg <= NUM_W'(diff) <<< FRAC_SHIFT_B;
                default:  tmp_reg <= mul_prod;
            endcase
        end
    end

    // determinant is never negative, so its low bits are the divisor
    lslf_div #(
        .N_W (NUM_W),
        .D_W (DIFF_W - 1)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den     (unsigned'(det_reg[DIFF_W-2:0])),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign det_zero = (det_reg == '0);

    always_ff @(posedge aclk) begin
        if (div_done && cmd.quot_to_slope) begin
            slope_reg <= div_quot;
        end
        if (cmd.out_load) begin
            out_reg.slope       <= det_zero ? '0 : $signed(slope_reg);
            out_reg.intercept   <= det_zero ? '0 : $signed(div_quot);
            out_reg.singular    <= det_zero;
            out_reg.points_used <= PTS_W'(cnt_reg);
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.det_zero = det_zero;
    assign out_data     = out_reg;

endmodule

// ===== design/lslf_ctrl.sv =====
// Controller: sequences accumulation, the normal-equation solve and output.
`timescale 1ns / 1ps

module lslf_ctrl
    import lslf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_xfer,
    input  logic      in_last,
    input  logic      m_ready,
    input  lslf_sts_t sts,
    output logic      s_ready,
    output logic      m_valid,
    output lslf_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_ACC,
        S_DRAIN,
        S_DET0,
        S_DET1,
        S_CHK,
        S_M0,
        S_M1,
        S_DIVM,
        S_B0,
        S_B1,
        S_DIVB,
        S_OUT
    } state_t;

    state_t    state_reg;
    lslf_cmd_t cmd_reg;
    logic      m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_ACC;
            cmd_reg     <= CMD_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            cmd_reg.mul_start <= 1'b0;
            cmd_reg.div_start <= 1'b0;
            cmd_reg.out_load  <= 1'b0;

            if (cmd_reg.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_ACC: begin
                    if (in_xfer && in_last) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    state_reg         <= S_DET0;
                    cmd_reg.mul_start <= 1'b1;
                    cmd_reg.mul_pair  <= MP_N_SXX;
                    cmd_reg.prod_dst  <= PD_TMP;
                end
                S_DET0: begin
                    if (sts.mul_done) begin
                        state_reg         <= S_DET1;
                        cmd_reg.mul_start <= 1'b1;
                        cmd_reg.mul_pair  <= MP_SX_SX;
                        cmd_reg.prod_dst  <= PD_DET;
                    end
                end
                S_DET1: begin
                    if (sts.mul_done) begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (sts.det_zero) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg         <= S_M0;
                        cmd_reg.mul_start <= 1'b1;
                        cmd_reg.mul_pair  <= MP_N_SXY;
                        cmd_reg.prod_dst  <= PD_TMP;
                    end
                end
                S_M0: begin
                    if (sts.mul_done) begin
                        state_reg         <= S_M1;
                        cmd_reg.mul_start <= 1'b1;
                        cmd_reg.mul_pair  <= MP_SX_SY;
                        cmd_reg.prod_dst  <= PD_NUM_M;
                    end
                end
                S_M1: begin
                    if (sts.mul_done) begin
                        state_reg             <= S_DIVM;
                        cmd_reg.div_start     <= 1'b1;
                        cmd_reg.quot_to_slope <= 1'b1;
                    end
                end
                S_DIVM: begin
                    if (sts.div_done) begin
                        state_reg             <= S_B0;
                        cmd_reg.quot_to_slope <= 1'b0;
                        cmd_reg.mul_start     <= 1'b1;
                        cmd_reg.mul_pair      <= MP_SXX_SY;
                        cmd_reg.prod_dst      <= PD_TMP;
                    end
                end
                S_B0: begin
                    if (sts.mul_done) begin
                        state_reg         <= S_B1;
                        cmd_reg.mul_start <= 1'b1;
                        cmd_reg.mul_pair  <= MP_SX_SXY;
                        cmd_reg.prod_dst  <= PD_NUM_B;
                    end
                end
                S_B1: begin
                    if (sts.mul_done) begin
                        state_reg         <= S_DIVB;
                        cmd_reg.div_start <= 1'b1;
                    end
                end
                S_DIVB: begin
                    if (sts.div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg        <= S_ACC;
                        cmd_reg.out_load <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_ACC;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_ACC);
    assign m_valid = m_valid_reg;
    assign cmd     = cmd_reg;

endmodule

// ===== design/least_squares_line_fit_unit.sv =====
// Top level of the least-squares straight-line fit unit.
`timescale 1ns / 1ps

// Usage:
//   Input channel (s_valid/s_ready/s_data) takes one point per transfer, x and y
//   in signed Q8.8. While a set is being collected s_ready stays high and one
//   point transfers every cycle. Points beyond MAX_POINTS in a set are dropped.
//   The point flagged last_point closes the set; s_ready then drops while the
//   normal equations are solved with one shared shift-add multiplier (six
//   products) and one restoring divider (two quotients), both one bit a cycle.
//   The x and y sums are SUM_W = 16+clog2(MAX_POINTS) bits wide and the divider
//   numerator is NUM_W = 2*SUM_W + 33 bits. A singular set skips the divides
//   and the last four products and goes straight to the output.
//   Result channel (m_valid/m_ready/m_data) carries slope and intercept in
//   signed Q16.16, the singular flag and the point count, from an output
//   register. The next set may stream in while a result waits; if the receiver
//   still stalls when the following solve ends, the unit holds until the
//   pending transfer completes. Reset (aresetn low, synchronous) clears all sums,
//   the count and any pending result.
module least_squares_line_fit_unit
    import lslf_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lslf_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lslf_out_t m_data
);

    logic      in_xfer;
    lslf_cmd_t cmd;
    lslf_sts_t sts;

    // a point moves on every cycle with valid and ready both high
    assign in_xfer = s_valid && s_ready;

    // sequence the solve; hold the result valid until it transfers
    lslf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_xfer (in_xfer),
        .in_last (s_data.last_point),
        .m_ready (m_ready),
        .sts     (sts),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    // sums, arithmetic units and the result register
    lslf_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (in_xfer),
        .in_data  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_data)
    );

endmodule

// ===== design/lslf_chk.sv =====
// Port-level checker for the line-fit unit, bound to the top level.
`timescale 1ns / 1ps

`include "least_squares_line_fit_unit_assert.svh"

module lslf_chk
    import lslf_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input lslf_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input lslf_out_t m_data
);

    // point count fits the result field without wrapping
    localparam bit CNT_FITS = (MAX_POINTS < (1 << PTS_W));

    `LSLF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    `LSLF_ASSERT_IMP(a_singular_zero, aclk, aresetn, m_valid && m_data.singular, (m_data.slope == 0) && (m_data.intercept == 0), "singular result not zero")
    `LSLF_ASSERT_NXT(a_last_stalls, aclk, aresetn, s_valid && s_ready && s_data.last_point, !s_ready, "input still ready after last point")
    `LSLF_ASSERT_IMP(a_count_nonzero, aclk, aresetn, CNT_FITS && m_valid, m_data.points_used != '0, "result with zero points")
    `LSLF_ASSERT_IMP(a_one_point, aclk, aresetn, CNT_FITS && m_valid && (m_data.points_used == PTS_W'(1)), m_data.singular, "single point not singular")

endmodule

bind least_squares_line_fit_unit lslf_chk #(
    .MAX_POINTS (MAX_POINTS)
) u_lslf_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== bench/line_fit_checker.sv =====
// Checker that predicts each line fit and compares it with the unit's result transfers.
`timescale 1ns / 1ps

module line_fit_checker
    import lslf_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  lslf_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  lslf_out_t m_data,
    output int        mismatch_count,
    output int        pending_fits,
    output int        fits_checked,
    output int        singular_fits,
    output int        clipped_fits
);

    localparam logic signed [127:0] QUOT_MAX = 128'sd2147483647;
    localparam logic signed [127:0] QUOT_MIN = -QUOT_MAX - 128'sd1;

    // Running sums of the set being collected, kept exact.
    int     set_size;
    longint run_sum_x;
    longint run_sum_y;
    longint run_sum_xy;
    longint run_sum_xx;

    lslf_out_t expected_fits[$];

    // Truncating divide, clamped to the signed 32-bit range.
    function automatic logic [RES_W-1:0] clamp_quotient(input logic signed [127:0] num,
                                                         input logic signed [127:0] den,
                                                         output bit clipped);
        logic signed [127:0] quot;
        begin
            quot    = num / den;
            clipped = 1'b0;
            if (quot > QUOT_MAX) begin
                clipped = 1'b1;
                return SAT_POS;
            end
            if (quot < QUOT_MIN) begin
                clipped = 1'b1;
                return SAT_NEG;
            end
            return quot[RES_W-1:0];
        end
    endfunction

    task automatic clear_sums();
        set_size   = 0;
        run_sum_x  = 0;
        run_sum_y  = 0;
        run_sum_xy = 0;
        run_sum_xx = 0;
    endtask

    // Accumulate one point; on the closing point solve the normal equations.
    task automatic accumulate_point(input lslf_in_t pt);
        lslf_out_t           fit;
        logic signed [127:0] n, sx, sy, sxy, sxx, det, num_m, num_b;
        bit                  clip_m, clip_b;
        begin
            if (set_size < MAX_POINTS) begin
                set_size++;
                run_sum_x  += longint'(pt.point_x);
                run_sum_y  += longint'(pt.point_y);
                run_sum_xy += longint'(pt.point_x) * longint'(pt.point_y);
                run_sum_xx += longint'(pt.point_x) * longint'(pt.point_x);
            end
            if (pt.last_point) begin
                n   = set_size;
                sx  = run_sum_x;
                sy  = run_sum_y;
                sxy = run_sum_xy;
                sxx = run_sum_xx;
                det = n * sxx - sx * sx;
                fit = '0;
                fit.points_used = PTS_W'(set_size);
                if (det == 0) begin
                    fit.singular = 1'b1;
                    singular_fits++;
                end else begin
                    num_m = (n * sxy - sx * sy) <<< FRAC_SHIFT_M;
                    num_b = (sxx * sy - sx * sxy) <<< FRAC_SHIFT_B;
                    fit.slope     = clamp_quotient(num_m, det, clip_m);
                    fit.intercept = clamp_quotient(num_b, det, clip_b);
                    if (clip_m || clip_b)
                        clipped_fits++;
                end
                expected_fits.push_back(fit);
                clear_sums();
            end
        end
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_fit(input lslf_out_t got);
        lslf_out_t want;
        begin
            if (expected_fits.size() == 0) begin
                $error("result transfer with no fit pending");
                mismatch_count++;
            end else begin
                want = expected_fits.pop_front();
                compare_field("slope", want.slope, got.slope);
                compare_field("intercept", want.intercept, got.intercept);
                compare_field("singular", want.singular, got.singular);
                compare_field("points_used", want.points_used, got.points_used);
                fits_checked++;
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        pending_fits   = 0;
        fits_checked   = 0;
        singular_fits  = 0;
        clipped_fits   = 0;
        clear_sums();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_sums();
            expected_fits.delete();
        end else begin
            if (s_valid && s_ready)
                accumulate_point(s_data);
            if (m_valid && m_ready)
                check_fit(m_data);
        end
        pending_fits = expected_fits.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the line-fit bench: clock, reset, point stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
    import lslf_pkg::*;

    localparam int MAX_POINTS    = DEF_MAX_POINTS;
    // Least number of points sent in each of the four handshake phases after the directed sets.
    localparam int PHASE_POINTS  = 308;
    // Longest quiet stretch is one solve plus a held result.
    localparam int STALL_LIMIT   = 5000;
    // Settle time after the last result, a little over one full solve.
    localparam int SETTLE_CYCLES = 400;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    lslf_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    lslf_out_t m_data;

    int mismatch_count;
    int pending_fits;
    int fits_checked;
    int singular_fits;
    int clipped_fits;

    int sender_idle_pct;
    int receiver_stall_pct;
    int points_sent;
    int no_progress_cycles;

    least_squares_line_fit_unit #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    line_fit_checker #(
        .MAX_POINTS(MAX_POINTS)
    ) fit_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_fits   (pending_fits),
        .fits_checked   (fits_checked),
        .singular_fits  (singular_fits),
        .clipped_fits   (clipped_fits)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: drop ready at random in the current stall ratio, update on the falling edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // Watchdog: end the run if neither channel moves a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            no_progress_cycles = 0;
        end else begin
            no_progress_cycles++;
            if (no_progress_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer in %0d cycles, %0d fits still pending",
                         no_progress_cycles, pending_fits);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Clamp an integer into the signed Q8.8 range of a coordinate.
    function automatic logic signed [COORD_W-1:0] to_q88(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return COORD_W'(v);
    endfunction

    function automatic int rand_coord();
        return int'($signed(16'($urandom)));
    endfunction

    // Present one point: idle at random first, then hold valid and payload
    // until the transfer happens. Valid stays high afterwards so the next
    // point can follow back to back.
    task automatic push_point(input int x, input int y, input bit closing);
        @(negedge aclk);
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_data.point_x    = to_q88(x);
        s_data.point_y    = to_q88(y);
        s_data.last_point = closing;
        do @(posedge aclk); while (!s_ready);
        points_sent++;
    endtask

    // Hold the input side quiet until every expected fit has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_fits != 0)
            @(negedge aclk);
    endtask

    // Send one set of points. Shapes: 0..2 full-range noise, 3..6 a noisy
    // line, 7 a single x value (singular), 8..9 x spread of one LSB with
    // full-range y, which drives the quotients into clipping.
    task automatic send_set(input int len, input int shape);
        int base_x, gain, offset, noise, shift, x, y, jitter;
        begin
            base_x = rand_coord();
            gain   = int'($urandom_range(0, 2048)) - 1024;
            offset = rand_coord();
            noise  = $urandom_range(0, 64);
            shift  = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                if (shape <= 2) begin
                    x = rand_coord();
                    y = rand_coord();
                end else if (shape <= 6) begin
                    jitter = int'($urandom_range(0, 2 * noise)) - noise;
                    x      = rand_coord() >>> shift;
                    y      = ((gain * x) >>> 8) + offset + jitter;
                end else if (shape == 7) begin
                    x = base_x;
                    y = rand_coord();
                end else begin
                    x = base_x + int'($urandom_range(0, 1));
                    y = rand_coord();
                end
                push_point(x, y, i == len - 1);
            end
        end
    endtask

    // Mostly short sets, some single points, some longer ones.
    function automatic int pick_length();
        int roll;
        begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
                return $urandom_range(2, 8);
            if (roll < 7)
                return $urandom_range(1, 2);
            return $urandom_range(9, 40);
        end
    endfunction

    initial begin
        int phase_sent;

        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        points_sent        = 0;
        no_progress_cycles = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed sets, no idling.
        // A lone point: one sample cannot fix a line.
        push_point(0, 0, 1'b1);
        // Two points on one vertical line at the top of the x range.
        push_point(32767, 32767, 1'b0);
        push_point(32767, -32768, 1'b1);
        // Opposite corners of the coordinate space.
        push_point(-32768, -32768, 1'b0);
        push_point(32767, 32767, 1'b1);
        // One LSB of run for a full-scale rise and fall: slope clips high, then low.
        push_point(0, -32768, 1'b0);
        push_point(1, 32767, 1'b1);
        push_point(0, 32767, 1'b0);
        push_point(1, -32768, 1'b1);
        // Steep line far from the origin: intercept clips too.
        push_point(32767, 0, 1'b0);
        push_point(32766, 32767, 1'b1);
        // Exact line y = x + 1.0.
        push_point(256, 512, 1'b0);
        push_point(512, 768, 1'b0);
        push_point(768, 1024, 1'b1);
        // Negative extremes mixed with zero.
        push_point(-32768, 0, 1'b0);
        push_point(0, 0, 1'b0);
        push_point(32767, -32768, 1'b1);

        // Pause the sender until every directed fit is out.
        wait_drained();

        // Random phases: none idle, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = (phase == 1) ? 75 : (phase == 3) ? 27 : 0;
            receiver_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 27 : 0;
            phase_sent         = points_sent;
            // Fill the point store exactly, then overrun it later on.
            if (phase == 0)
                send_set(MAX_POINTS, 3);
            if (phase == 2)
                send_set($urandom_range(MAX_POINTS + 1, MAX_POINTS + 44), 0);
            while (points_sent - phase_sent < PHASE_POINTS)
                send_set(pick_length(), $urandom_range(0, 9));
            wait_drained();
        end

        // Let the unit settle to catch any stray result.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d points in %0d checked fits (%0d singular, %0d with clipped quotients),",
                 points_sent, fits_checked, singular_fits, clipped_fits);
        $display("across four idle and stall mixes, with sets at and past the point limit.");
        if (mismatch_count == 0 && pending_fits == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== least_squares_line_fit_unit.f =====
+incdir+design
design/lslf_pkg.sv
design/lslf_mul.sv
design/lslf_div.sv
design/lslf_dp.sv
design/lslf_ctrl.sv
design/least_squares_line_fit_unit.sv
design/lslf_chk.sv
bench/line_fit_checker.sv
bench/testbench.sv
